// File: rtl/core/wncg_pkg.sv
// Package: types, constants and helper functions for the weighted neighbor color gradient.
`timescale 1ns / 1ps

package wncg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = 10;
  localparam int CNT_W      = 20;
  localparam int TOTAL_W    = 21;
  localparam int FEAT_W     = 16;
  localparam int GRAD_W     = 18;
  localparam int CFG_IDX_W  = 2;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int CRED_W     = 5;
  localparam int DIV_STEPS  = CNT_W;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [13:0] W_AXIAL = 14'd9598;
  localparam logic [13:0] W_DIAG  = 14'd6786;
  localparam logic [GRAD_W:0] GRAD_MAX = 19'd262143;

  localparam logic [DIM_W-1:0]   RESET_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]   RESET_HEIGHT = 11'd480;
  localparam logic [TOTAL_W-1:0] RESET_TOTAL  = 21'd307200;

  typedef struct packed {
    logic                     mode;
    logic signed [FEAT_W-1:0] feat_l;
    logic signed [FEAT_W-1:0] feat_a;
    logic signed [FEAT_W-1:0] feat_b;
  } in_t;

  typedef struct packed {
    logic [GRAD_W-1:0]  gradient;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last;
  } out_t;

  typedef logic [2:0][FEAT_W-1:0] pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               last;
    logic [7:0]         mask;
  } meta_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > vmax) r = vmax;
    else r = v;
    return r;
  endfunction

  function automatic logic [1:0] nb_row(input logic [2:0] k);
    logic [1:0] r;
    if (k < 3'd3) r = 2'd0;
    else if (k < 3'd5) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  function automatic logic [1:0] nb_col(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0, 3'd3, 3'd5: c = 2'd0;
      3'd1, 3'd6:       c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [13:0] nb_weight(input logic [2:0] k);
    logic [13:0] wt;
    case (k)
      3'd1, 3'd3, 3'd4, 3'd6: wt = W_AXIAL;
      default:                wt = W_DIAG;
    endcase
    return wt;
  endfunction

endpackage

// File: rtl/core/weighted_neighbor_color_gradient.sv
// Top level: raster line stores, 3x3 window and pipelined weighted neighbor L1 gradient.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_data   (mode, feat_l, feat_a, feat_b)
//  out_    | output    | out_valid / out_stall| out_data  (gradient, pixel_x, pixel_y, last)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while in_stall is low.
//  Line stores are two 1024 x 48 synchronous-read RAMs; upper is written in the cycle after its read.
//  A register write stalls input while a shift-subtract divider re-derives
//  the column and row of the next result from the result count.
//  Reset is synchronous: counters, window and valid bits clear, line stores keep contents.
//  Up to 16 results wait in the output queue; input stalls when that credit runs out or the divider is busy.

module weighted_neighbor_color_gradient (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wncg_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wncg_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wncg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wncg_pkg::DIM_W-1:0]           cfg_data
);

  logic [wncg_pkg::DIM_W-1:0]   w_r, h_r;
  logic [wncg_pkg::TOTAL_W-1:0] total_r;
  logic [wncg_pkg::CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [wncg_pkg::DIM_W-1:0]   in_col_r, in_col_nxt;
  logic [wncg_pkg::DIM_W-1:0]   in_row_r, in_row_nxt;
  logic                         input_done_r, input_done_nxt;
  logic [wncg_pkg::COORD_W-1:0] tx_r, tx_nxt;
  logic [wncg_pkg::CNT_W-1:0]   ty_r, ty_nxt;

  logic [wncg_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [wncg_pkg::DIM_W-1:0]     div_rem_r, div_rem_nxt;
  logic [wncg_pkg::CNT_W-1:0]     div_q_r, div_q_nxt;
  logic [wncg_pkg::DIM_W:0]       div_sh;
  logic                           div_ge;
  logic                           div_busy;

  logic                           cfg_fire;
  logic                           in_acc, tick, has_res, res_fire, is_last;
  wncg_pkg::pix_t                 cur;
  logic [wncg_pkg::COORD_W-1:0]   col;
  logic [wncg_pkg::DIM_W-1:0]     col_inc, row_inc;
  logic                           wrap;
  logic [wncg_pkg::DIM_W-1:0]     tx_inc;
  logic [wncg_pkg::TOTAL_W-1:0]   ty_inc;
  logic                           nb_l, nb_r, nb_u, nb_d;
  wncg_pkg::meta_t                meta0;

  wncg_pkg::pix_t upper_mem [wncg_pkg::MAX_WIDTH];
  wncg_pkg::pix_t middle_mem [wncg_pkg::MAX_WIDTH];
  wncg_pkg::pix_t up_q, mid_q, up_in;

  logic                         s1_tick_r, s1_res_r;
  logic [wncg_pkg::COORD_W-1:0] s1_col_r;
  wncg_pkg::pix_t               s1_cur_r;
  wncg_pkg::meta_t              s1_meta_r;
  logic                         fwd_r;
  wncg_pkg::pix_t               fwd_data_r;

  wncg_pkg::pix_t window_r [3][3];

  logic            va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  wncg_pkg::meta_t ma_r, mb_r, mc_r, md_r, me_r, mf_r;
  logic [15:0] abs_r [8][3];
  logic [15:0] abs_nxt [8][3];
  logic [17:0] l1_r [8];
  logic [17:0] l1_nxt [8];
  logic [31:0] prod_r [8];
  logic [32:0] pair_r [4];
  logic [33:0] quad_r [2];
  logic [34:0] tot;
  logic [wncg_pkg::GRAD_W:0] g_full;
  wncg_pkg::out_t res_word;

  wncg_pkg::out_t                fifo_mem [wncg_pkg::FIFO_DEPTH];
  logic [wncg_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [wncg_pkg::CRED_W-1:0]   fifo_cnt_r, cred_r;
  logic                          push, pop;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign div_busy  = div_cnt_r != '0;

  assign in_stall = div_busy || (cred_r >= wncg_pkg::CRED_W'(wncg_pkg::FIFO_DEPTH));
  assign in_acc   = in_valid & ~in_stall;
  assign tick     = in_acc & ~((in_data.mode == wncg_pkg::MODE_FLUSH) & ~input_done_r);
  assign cur      = input_done_r ? '0 : {in_data.feat_l, in_data.feat_a, in_data.feat_b};
  assign col      = in_col_r[wncg_pkg::COORD_W-1:0];

  assign has_res  = (in_row_r >= 11'd2) || (in_row_r == 11'd1 && in_col_r != '0) ||
                    (in_row_r == '0 && in_col_r > w_r);
  assign res_fire = tick & has_res;
  assign is_last  = ({1'b0, out_count_r} + 21'd1) >= total_r;

  assign col_inc  = in_col_r + 11'd1;
  assign wrap     = col_inc >= w_r;
  assign row_inc  = (in_row_r == '1) ? in_row_r : in_row_r + 11'd1;
  assign tx_inc   = {1'b0, tx_r} + 11'd1;
  assign ty_inc   = {1'b0, ty_r} + 21'd1;

  assign nb_l = tx_r != '0;
  assign nb_r = tx_inc < w_r;
  assign nb_u = ty_r != '0;
  assign nb_d = ty_inc < {10'd0, h_r};

  always_comb begin
    meta0.px   = tx_r;
    meta0.py   = ty_r[wncg_pkg::COORD_W-1:0];
    meta0.last = is_last;
    meta0.mask = {nb_d & nb_r, nb_d, nb_d & nb_l, nb_r, nb_l, nb_u & nb_r, nb_u, nb_u & nb_l};
  end

  assign div_sh      = {div_rem_r, div_q_r[wncg_pkg::CNT_W-1]};
  assign div_ge      = div_sh >= {1'b0, w_r};
  assign div_rem_nxt = div_ge ? wncg_pkg::DIM_W'(div_sh - {1'b0, w_r})
                              : div_sh[wncg_pkg::DIM_W-1:0];
  assign div_q_nxt   = {div_q_r[wncg_pkg::CNT_W-2:0], div_ge};

  always_comb begin
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    input_done_nxt = input_done_r;
    out_count_nxt  = out_count_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    if (tick) begin
      in_col_nxt = wrap ? '0 : col_inc;
      if (wrap) begin
        in_row_nxt = row_inc;
        if (row_inc >= h_r) input_done_nxt = 1'b1;
      end
    end
    if (res_fire) begin
      if (is_last) begin
        in_col_nxt     = '0;
        in_row_nxt     = '0;
        input_done_nxt = 1'b0;
        out_count_nxt  = '0;
        tx_nxt         = '0;
        ty_nxt         = '0;
      end else begin
        out_count_nxt = out_count_r + 20'd1;
        if (tx_inc == w_r) begin
          tx_nxt = '0;
          ty_nxt = ty_inc[wncg_pkg::CNT_W-1:0];
        end else begin
          tx_nxt = tx_inc[wncg_pkg::COORD_W-1:0];
        end
      end
    end else if (div_cnt_r == wncg_pkg::DIV_CNT_W'(1)) begin
      tx_nxt = div_rem_nxt[wncg_pkg::COORD_W-1:0];
      ty_nxt = div_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= wncg_pkg::RESET_WIDTH;
      h_r          <= wncg_pkg::RESET_HEIGHT;
      total_r      <= wncg_pkg::RESET_TOTAL;
      in_col_r     <= '0;
      in_row_r     <= '0;
      input_done_r <= 1'b0;
      out_count_r  <= '0;
      tx_r         <= '0;
      ty_r         <= '0;
      div_cnt_r    <= '0;
    end else begin
      total_r      <= {10'd0, w_r} * {10'd0, h_r};
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      input_done_r <= input_done_nxt;
      out_count_r  <= out_count_nxt;
      tx_r         <= tx_nxt;
      ty_r         <= ty_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          wncg_pkg::REG_WIDTH:
            w_r <= wncg_pkg::clamp_dim(cfg_data, wncg_pkg::DIM_W'(wncg_pkg::MAX_WIDTH));
          wncg_pkg::REG_HEIGHT:
            h_r <= wncg_pkg::clamp_dim(cfg_data, wncg_pkg::DIM_W'(wncg_pkg::MAX_HEIGHT));
          default: ;
        endcase
        div_cnt_r <= wncg_pkg::DIV_CNT_W'(wncg_pkg::DIV_STEPS);
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - wncg_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_fire) begin
      div_rem_r <= '0;
      div_q_r   <= out_count_r;
    end else if (div_busy) begin
      div_rem_r <= div_rem_nxt;
      div_q_r   <= div_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      up_q               <= upper_mem[col];
      mid_q              <= middle_mem[col];
      middle_mem[col]    <= cur;
    end
    if (s1_tick_r) begin
      upper_mem[s1_col_r] <= mid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tick_r <= 1'b0;
      s1_res_r  <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      s1_tick_r <= tick;
      s1_res_r  <= res_fire;
      if (tick) fwd_r <= s1_tick_r && (s1_col_r == col);
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_col_r   <= col;
      s1_cur_r   <= cur;
      s1_meta_r  <= meta0;
      fwd_data_r <= mid_q;
    end
  end

  assign up_in = fwd_r ? fwd_data_r : up_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          window_r[r][c] <= '0;
        end
      end
    end else if (s1_tick_r) begin
      for (int r = 0; r < 3; r++) begin
        window_r[r][0] <= window_r[r][1];
        window_r[r][1] <= window_r[r][2];
      end
      window_r[0][2] <= up_in;
      window_r[1][2] <= mid_q;
      window_r[2][2] <= s1_cur_r;
    end
  end

  always_comb begin
    logic [16:0] d;
    logic [15:0] nv, cv;
    for (int k = 0; k < 8; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        nv = window_r[wncg_pkg::nb_row(3'(k))][wncg_pkg::nb_col(3'(k))][ch];
        cv = window_r[1][1][ch];
        d  = {nv[15], nv} - {cv[15], cv};
        abs_nxt[k][ch] = d[16] ? 16'(17'd0 - d) : d[15:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      l1_nxt[k] = mb_r.mask[k] ? ({2'd0, abs_r[k][0]} + {2'd0, abs_r[k][1]} +
                                  {2'd0, abs_r[k][2]}) : 18'd0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        abs_r[k][ch] <= abs_nxt[k][ch];
      end
      l1_r[k]   <= l1_nxt[k];
      prod_r[k] <= {14'd0, l1_r[k]} * {18'd0, wncg_pkg::nb_weight(3'(k))};
    end
    for (int p = 0; p < 4; p++) begin
      pair_r[p] <= {1'b0, prod_r[2*p]} + {1'b0, prod_r[2*p+1]};
    end
    for (int q = 0; q < 2; q++) begin
      quad_r[q] <= {1'b0, pair_r[2*q]} + {1'b0, pair_r[2*q+1]};
    end
    ma_r <= s1_meta_r;
    mb_r <= ma_r;
    mc_r <= mb_r;
    md_r <= mc_r;
    me_r <= md_r;
    mf_r <= me_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      va_r <= s1_res_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  assign tot    = {1'b0, quad_r[0]} + {1'b0, quad_r[1]};
  assign g_full = tot[34:16];

  always_comb begin
    res_word.gradient = (g_full > wncg_pkg::GRAD_MAX) ? wncg_pkg::GRAD_MAX[wncg_pkg::GRAD_W-1:0]
                                                      : g_full[wncg_pkg::GRAD_W-1:0];
    res_word.pixel_x  = mf_r.px;
    res_word.pixel_y  = mf_r.py;
    res_word.last     = mf_r.last;
  end

  assign push      = vf_r;
  assign out_valid = fifo_cnt_r != '0;
  assign pop       = out_valid & ~out_stall;
  assign out_data  = fifo_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr_r] <= res_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      cred_r     <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + wncg_pkg::FIFO_AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + wncg_pkg::FIFO_AW'(1);
      fifo_cnt_r <= fifo_cnt_r + wncg_pkg::CRED_W'(push) - wncg_pkg::CRED_W'(pop);
      cred_r     <= cred_r + wncg_pkg::CRED_W'(res_fire) - wncg_pkg::CRED_W'(pop);
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy |-> ({1'b0, tx_r} < w_r))
    else $error("next result column outside the image width");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= cred_r)
    else $error("output queue holds more results than credited");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= wncg_pkg::CRED_W'(wncg_pkg::FIFO_DEPTH))
    else $error("result credit exceeds queue depth");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && is_last) |=> (out_count_r == '0 && in_col_r == '0 &&
                               in_row_r == '0 && !input_done_r))
    else $error("frame counters not cleared after last result");

endmodule
